FILE: rtl/core/cs2s_pkg.sv
// Shared constants, payload types and register codes for the cos-2s spreading block.
package cs2s_pkg;

  localparam int ANGLE_BITS_DEF    = 16;
  localparam int OUT_FRAC_BITS_DEF = 20;

  localparam logic [15:0] SPREAD_RST = 16'd256;
  localparam longint     NORM_RST   = 333772;

  // Q30 fixed point, 1.0 needs 31 bits
  localparam logic [30:0] ONE_Q = 31'h4000_0000;

  // Taylor coefficients of cos(pi/2 * u) in powers of u^2, Q30
  localparam logic [30:0] CK1 = 31'd1324675879;
  localparam logic [30:0] CK2 = 31'd272375560;
  localparam logic [30:0] CK3 = 31'd22401991;
  localparam logic [30:0] CK4 = 31'd987048;
  localparam logic [30:0] CK5 = 31'd27061;

  localparam logic [29:0] LN2_Q30 = 30'd744261118;

  typedef enum logic [1:0] {
    CFG_SPREAD = 2'd0,
    CFG_NORM   = 2'd1,
    CFG_MEAN   = 2'd2
  } cfg_idx_t;

  // polynomial chain payload
  typedef struct packed {
    logic [30:0] t;
    logic [30:0] u2;
    logic        bz;
  } poly_t;

  // log2 chain payload
  typedef struct packed {
    logic [30:0] m;
    logic [4:0]  n;
    logic [29:0] frac;
    logic        bz;
  } log_t;

  // exp chain payload
  typedef struct packed {
    logic [30:0] t;
    logic [29:0] x;
    logic [4:0]  k;
    logic        kbig;
    logic        bz;
  } expo_t;

endpackage

FILE: rtl/core/cs2s_dir_if.sv
// Direction input channel: valid/ready handshake with a signed angle payload.
interface cs2s_dir_if import cs2s_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [ANGLE_BITS-1:0] direction;

  modport source (output valid, output direction, input ready);
  modport sink   (input valid, input direction, output ready);
endinterface

FILE: rtl/core/cs2s_dens_if.sv
// Density result channel: valid/ready handshake with an unsigned fixed-point payload.
interface cs2s_dens_if import cs2s_pkg::*; #(
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [OUT_FRAC_BITS+3:0]   density;

  modport source (output valid, output density, input ready);
  modport sink   (input valid, input density, output ready);
endinterface

FILE: rtl/core/cos_2s_directional_spreading.sv
// cos-2s directional spreading density: density = C_s * cos(d/2)^(2s), d wrapped.
//
// Usage: in_chan carries one signed direction per beat (32768 counts = pi at
// 16 bits); out_chan returns one density beat, unsigned Q4.20, per input beat
// in the same order. Both channels move a beat when valid and ready are high.
// Configuration: write spread s (Q8.8), C_s (Q4.20) and the mean direction by
// cfg_we/cfg_addr/cfg_wdata while no beat is in flight.
// Throughput: one beat per cycle while out_chan is ready; every stage is a cell with its own valid
// and the stage ready chain lets a new beat in whenever any stage ahead has a
// bubble, including while the output register holds a result.
// The pipeline: wrap and square u, a four-cell Horner chain for the cosine,
// five shift cells and thirty squaring cells for -log2, one multiply by s,
// nine three-stage Taylor cells for 2^-E, then scale by C_s and clamp.
// Reset: all cells empty, s = 1.0, C_s = 333772, mean = 0.
// Receiver stall: beats stack up in the cells; input stalls once all are full.
module cos_2s_directional_spreading import cs2s_pkg::*; #(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
  localparam int OutBits      = OUT_FRAC_BITS + 4,
  localparam int WideA        = (ANGLE_BITS > 16) ? ANGLE_BITS : 16,
  localparam int CfgW         = (OutBits > WideA) ? OutBits : WideA
) (
  input  logic              clk,
  input  logic              rst_n,
  cs2s_dir_if.sink          in_chan,
  cs2s_dens_if.source       out_chan,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_addr,
  input  logic [CfgW-1:0]   cfg_wdata
);
  localparam int          NLOG = 35;
  localparam int          NEXP = 9;
  localparam logic [ANGLE_BITS-1:0] HALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};

  // configuration registers
  logic [15:0]            spread_r;
  logic [OutBits-1:0]     norm_r;
  logic [ANGLE_BITS-1:0]  mean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spread_r <= SPREAD_RST;
      norm_r   <= OutBits'(NORM_RST);
      mean_r   <= '0;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_SPREAD) spread_r <= cfg_wdata[15:0];
      if (cfg_addr == CFG_NORM)   norm_r   <= cfg_wdata[OutBits-1:0];
      if (cfg_addr == CFG_MEAN)   mean_r   <= cfg_wdata[ANGLE_BITS-1:0];
    end
  end

  // stage valids and the ready chain
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic en1, en2, en3, en4, en5, en6, en7;

  poly_t poly_d   [0:4];
  logic  poly_v   [0:4];
  logic  poly_rdy [0:4];
  log_t  lg_d     [0:NLOG];
  logic  lg_v     [0:NLOG];
  logic  lg_rdy   [0:NLOG];
  expo_t ex_d     [0:NEXP];
  logic  ex_v     [0:NEXP];
  logic  ex_rdy   [0:NEXP];

  assign en7 = !v7_r || out_chan.ready;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || ex_rdy[0];
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || lg_rdy[0];
  assign en2 = !v2_r || poly_rdy[0];
  assign en1 = !v1_r || en2;

  assign in_chan.ready = en1;
  assign poly_rdy[4]   = en3;
  assign lg_rdy[NLOG]  = en4;
  assign ex_rdy[NEXP]  = en6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_chan.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= poly_v[4];
      if (en4) v4_r <= lg_v[NLOG];
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= ex_v[NEXP];
      if (en7) v7_r <= v6_r;
    end
  end

  // stage 1: wrap the difference, fold to magnitude, scale to Q30
  logic [ANGLE_BITS-1:0] diff, mag;
  logic [ANGLE_BITS+30:0] uw;
  logic [30:0]           u1_r;
  logic                  z1_r;

  always_comb begin
    diff = ANGLE_BITS'(in_chan.direction - mean_r);
    mag  = diff[ANGLE_BITS-1] ? ANGLE_BITS'(-diff) : diff;
    uw   = {mag, 31'b0} >> ANGLE_BITS;
  end

  // stage 2: u squared
  logic [61:0] usq;
  poly_t       p2_r;

  assign usq = u1_r * u1_r;

  // stage 3: last product, base of the power
  logic [61:0] tprod;
  logic [31:0] term;
  logic [30:0] base3_r;
  logic        bz3_r;

  assign tprod = poly_d[4].t * poly_d[4].u2;
  assign term  = tprod[61:30];

  // stage 4: E = 2*s*(-log2 base)
  logic [34:0] lval;
  logic [50:0] eprod;
  logic [43:0] e4_r;
  logic        bz4_r;

  always_comb begin
    lval  = {lg_d[NLOG].n, 30'b0} - {5'b0, lg_d[NLOG].frac};
    eprod = lval * spread_r;
  end

  // stage 5: split E into shift and fraction times ln2
  logic [59:0] xprod;
  expo_t       x5_r;

  assign xprod = e4_r[29:0] * LN2_Q30;

  // stage 6: apply the integer shift and the special cases
  logic [30:0] r6_r;
  logic [30:0] r_nxt;

  always_comb begin
    if (spread_r == '0) begin
      r_nxt = ONE_Q;
    end else if (ex_d[NEXP].bz || ex_d[NEXP].kbig) begin
      r_nxt = '0;
    end else begin
      r_nxt = ex_d[NEXP].t >> ex_d[NEXP].k;
    end
  end

  // stage 7: scale by C_s and clamp
  logic [OutBits+30:0] sprod;
  logic [OutBits:0]    scaled;
  logic [OutBits-1:0]  dens_r;

  always_comb begin
    sprod  = norm_r * r6_r;
    scaled = sprod[OutBits+30:30];
  end

  always_ff @(posedge clk) begin
    if (en1 && in_chan.valid) begin
      u1_r <= uw[30:0];
      z1_r <= (mag == HALF);
    end
    if (en2 && v1_r) begin
      p2_r.t  <= CK5;
      p2_r.u2 <= usq[60:30];
      p2_r.bz <= z1_r;
    end
    if (en3 && poly_v[4]) begin
      base3_r <= 31'(32'(ONE_Q) - term);
      bz3_r   <= poly_d[4].bz || (term >= 32'(ONE_Q));
    end
    if (en4 && lg_v[NLOG]) begin
      e4_r  <= eprod[50:7];
      bz4_r <= lg_d[NLOG].bz;
    end
    if (en5 && v4_r) begin
      x5_r.t    <= ONE_Q;
      x5_r.x    <= xprod[59:30];
      x5_r.k    <= e4_r[34:30];
      x5_r.kbig <= |e4_r[43:35];
      x5_r.bz   <= bz4_r;
    end
    if (en6 && ex_v[NEXP]) begin
      r6_r <= r_nxt;
    end
    if (en7 && v6_r) begin
      dens_r <= scaled[OutBits] ? '1 : scaled[OutBits-1:0];
    end
  end

  // cosine polynomial chain
  assign poly_d[0] = p2_r;
  assign poly_v[0] = v2_r;

  localparam logic [30:0] COEFS [0:3] = '{CK4, CK3, CK2, CK1};

  for (genvar i = 0; i < 4; i++) begin : g_horner
    cs2s_horner_cell #(.COEF(COEFS[i])) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (poly_v[i]),
      .up_ready (poly_rdy[i]),
      .up_data  (poly_d[i]),
      .dn_valid (poly_v[i+1]),
      .dn_ready (poly_rdy[i+1]),
      .dn_data  (poly_d[i+1])
    );
  end

  // -log2 chain: five shift cells then thirty squaring cells
  assign lg_d[0] = '{m: base3_r, n: 5'd0, frac: 30'd0, bz: bz3_r};
  assign lg_v[0] = v3_r;

  for (genvar i = 0; i < NLOG; i++) begin : g_log
    if (i < 5) begin : g_norm
      cs2s_norm_cell #(.SH(16 >> i)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (lg_v[i]),
        .up_ready (lg_rdy[i]),
        .up_data  (lg_d[i]),
        .dn_valid (lg_v[i+1]),
        .dn_ready (lg_rdy[i+1]),
        .dn_data  (lg_d[i+1])
      );
    end else begin : g_sq
      cs2s_sq_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (lg_v[i]),
        .up_ready (lg_rdy[i]),
        .up_data  (lg_d[i]),
        .dn_valid (lg_v[i+1]),
        .dn_ready (lg_rdy[i+1]),
        .dn_data  (lg_d[i+1])
      );
    end
  end

  // e^-x chain, divisors nine down to one
  assign ex_d[0] = x5_r;
  assign ex_v[0] = v5_r;

  for (genvar i = 0; i < NEXP; i++) begin : g_exp
    cs2s_exp_cell #(.J(NEXP - i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (ex_v[i]),
      .up_ready (ex_rdy[i]),
      .up_data  (ex_d[i]),
      .dn_valid (ex_v[i+1]),
      .dn_ready (ex_rdy[i+1]),
      .dn_data  (ex_d[i+1])
    );
  end

  assign out_chan.valid   = v7_r;
  assign out_chan.density = dens_r;

  // a live base lies in (0, 1.0]
  a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !bz3_r) |-> (base3_r != '0 && base3_r <= ONE_Q))
    else $error("base out of range");

  // normalization leaves the mantissa in [1, 2)
  a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
    (lg_v[5] && !lg_d[5].bz) |-> lg_d[5].m[30])
    else $error("mantissa not normalized");

  // the power never exceeds 1.0
  a_power_le_one: assert property (@(posedge clk) disable iff (!rst_n)
    v6_r |-> (r6_r <= ONE_Q))
    else $error("power above one");

endmodule

FILE: rtl/core/cs2s_horner_cell.sv
// One Horner step of the cosine polynomial: t <= COEF - t*u2.
module cs2s_horner_cell import cs2s_pkg::*; #(
  parameter logic [30:0] COEF = CK4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  poly_t up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output poly_t dn_data
);
  logic        v_r;
  logic        en;
  logic [61:0] prod;
  poly_t       data_r;
  poly_t       data_nxt;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  always_comb begin
    prod       = up_data.t * up_data.u2;
    data_nxt   = up_data;
    data_nxt.t = 31'(32'(COEF) - prod[61:30]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      data_r <= data_nxt;
    end
  end
endmodule

FILE: rtl/core/cs2s_norm_cell.sv
// One normalize step: shift the mantissa left by SH when its top SH bits are clear.
module cs2s_norm_cell import cs2s_pkg::*; #(
  parameter int SH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  log_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output log_t dn_data
);
  logic v_r;
  logic en;
  log_t data_r;
  log_t data_nxt;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  always_comb begin
    data_nxt = up_data;
    if (up_data.m[30 -: SH] == '0) begin
      data_nxt.m = up_data.m << SH;
      data_nxt.n = up_data.n + 5'(SH);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      data_r <= data_nxt;
    end
  end
endmodule

FILE: rtl/core/cs2s_sq_cell.sv
// One fraction bit of log2: square the mantissa and renormalize.
module cs2s_sq_cell import cs2s_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_ready,
  input  log_t up_data,
  output logic dn_valid,
  input  logic dn_ready,
  output log_t dn_data
);
  logic        v_r;
  logic        en;
  logic [61:0] prod;
  logic [31:0] m2;
  log_t        data_r;
  log_t        data_nxt;

  assign en       = !v_r || dn_ready;
  assign up_ready = en;
  assign dn_valid = v_r;
  assign dn_data  = data_r;

  always_comb begin
    prod          = up_data.m * up_data.m;
    m2            = prod[61:30];
    data_nxt      = up_data;
    data_nxt.m    = m2[31] ? m2[31:1] : m2[30:0];
    data_nxt.frac = {up_data.frac[28:0], m2[31]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      data_r <= data_nxt;
    end
  end
endmodule

FILE: rtl/core/cs2s_exp_cell.sv
// One nested Taylor step of e^-x: t <= 1 - floor(x*t / J), three register stages.
module cs2s_exp_cell import cs2s_pkg::*; #(
  parameter int J = 9
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  up_valid,
  output logic  up_ready,
  input  expo_t up_data,
  output logic  dn_valid,
  input  logic  dn_ready,
  output expo_t dn_data
);
  localparam logic [32:0] RECIP = 33'((64'd1 << 32) / J);

  logic        v1_r, v2_r, v3_r;
  logic        en1, en2, en3;
  expo_t       pl1_r, pl2_r, pl3_r;
  logic [29:0] p1_r, p2_r, q2_r;
  logic [60:0] xt;
  logic [62:0] qm;
  logic [33:0] qj;
  logic [33:0] rem;
  logic [29:0] q;
  expo_t       pl3_nxt;

  assign en3      = !v3_r || dn_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;
  assign dn_valid = v3_r;
  assign dn_data  = pl3_r;

  always_comb begin
    xt         = up_data.x * up_data.t;
    qm         = p1_r * RECIP;
    // quotient estimate is exact or one short; fix with one compare
    qj         = q2_r * 4'(J);
    rem        = {4'b0, p2_r} - qj;
    q          = q2_r + 30'(rem >= 34'(J));
    pl3_nxt    = pl2_r;
    pl3_nxt.t  = ONE_Q - {1'b0, q};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && up_valid) begin
      pl1_r <= up_data;
      p1_r  <= xt[59:30];
    end
    if (en2 && v1_r) begin
      pl2_r <= pl1_r;
      p2_r  <= p1_r;
      q2_r  <= qm[61:32];
    end
    if (en3 && v2_r) begin
      pl3_r <= pl3_nxt;
    end
  end
endmodule

FILE: bench/cs2s_checker.sv
`timescale 1ns / 1ps
// Checker: predicts each density from the observed direction beats and compares results.
module cs2s_checker import cs2s_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               dir_valid,
  input  logic               dir_ready,
  input  logic signed [15:0] direction,
  input  logic               dens_valid,
  input  logic               dens_ready,
  input  logic [23:0]        density,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [23:0]        cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  typedef longint unsigned u64_t;
  localparam u64_t ONE = 64'd1 << 30;

  logic [15:0] spread;
  logic [23:0] norm_cs;
  logic [15:0] mean_dir;
  logic [23:0] density_due[$];

  // cos(pi/2*u) in Q30, zero when the polynomial reaches zero or below
  function automatic u64_t half_angle_cos(u64_t u);
    u64_t u2, t, term;
    u2   = (u * u) >> 30;
    t    = 64'(CK5);
    t    = 64'(CK4) - ((t * u2) >> 30);
    t    = 64'(CK3) - ((t * u2) >> 30);
    t    = 64'(CK2) - ((t * u2) >> 30);
    t    = 64'(CK1) - ((t * u2) >> 30);
    term = (t * u2) >> 30;
    return (term >= ONE) ? 64'd0 : ONE - term;
  endfunction

  // -log2(c) in Q30
  function automatic u64_t log2_depth(u64_t c);
    u64_t n, frac, m;
    n = 0;
    frac = 0;
    m = c;
    while (m < ONE) begin
      m = m << 1;
      n++;
    end
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (ONE << 1)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (n << 30) - frac;
  endfunction

  // 2^-e in Q30
  function automatic u64_t pow2_neg(u64_t e);
    u64_t k, x, t;
    k = e >> 30;
    x = ((e & (ONE - 1)) * 64'(LN2_Q30)) >> 30;
    t = ONE;
    for (int j = 9; j >= 1; j--) t = ONE - ((x * t) >> 30) / u64_t'(j);
    return (k >= 32) ? 64'd0 : t >> k;
  endfunction

  function automatic logic [23:0] density_of(logic [15:0] dir);
    logic [15:0] diff;
    u64_t mag, base, r, hi, lo, res;
    diff = dir - mean_dir;
    mag  = diff[15] ? (u64_t'(65536) - diff) : u64_t'(diff);
    base = (mag == 64'd32768) ? 64'd0 : half_angle_cos(mag << 15);
    if (spread == 0) r = ONE;
    else if (base == 0) r = 0;
    else r = pow2_neg((log2_depth(base) * u64_t'(spread)) >> 7);
    hi  = u64_t'(norm_cs >> 22) * r;
    lo  = u64_t'(norm_cs & 24'h3FFFFF) * r;
    res = (hi >> 8) + ((((hi & 64'd255) << 22) + lo) >> 30);
    if (res > 64'hFFFFFF) res = 64'hFFFFFF;
    return res[23:0];
  endfunction

  task automatic report(string what, logic [23:0] got, logic [23:0] want);
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = density_due.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      spread   <= SPREAD_RST;
      norm_cs  <= 24'(NORM_RST);
      mean_dir <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SPREAD: spread   <= cfg_wdata[15:0];
          CFG_NORM:   norm_cs  <= cfg_wdata;
          CFG_MEAN:   mean_dir <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (dir_valid && dir_ready) density_due.push_back(density_of(direction));
      if (dens_valid && dens_ready) begin
        if (density_due.size() == 0) report("unexpected density", density, 24'd0);
        else begin
          logic [23:0] want;
          want = density_due.pop_front();
          if (density !== want) report("density", density, want);
        end
      end
    end
  end

endmodule

FILE: bench/cos_2s_directional_spreading_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives directions and register writes, gives the verdict.
module cos_2s_directional_spreading_tb;
  import cs2s_pkg::*;

  localparam logic [1:0] CFG_NONE = 2'd3;   // index past the register list
  localparam int LATENCY = 80;
  localparam int LIMIT   = 600000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = CFG_SPREAD;
  logic [23:0] cfg_wdata = '0;
  int fail_count, pending;
  int cycles = 0;

  // receiver pattern controls
  bit calm = 1'b0;          // no idling on either side
  int hold_req = 0;         // cycles the receiver must hold off

  logic signed [15:0] mean_now;

  cs2s_dir_if  #(.ANGLE_BITS(16))    in_chan();
  cs2s_dens_if #(.OUT_FRAC_BITS(20)) out_chan();

  cos_2s_directional_spreading DUT (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  cs2s_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .dir_valid(in_chan.valid), .dir_ready(in_chan.ready), .direction(in_chan.direction),
    .dens_valid(out_chan.valid), .dens_ready(out_chan.ready), .density(out_chan.density),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.direction = '0;
    out_chan.ready = 1'b0;
  end

  // watchdog: stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off counted here when requested
  always @(negedge clk) begin
    if (hold_req > 0) begin
      out_chan.ready = 1'b0;
      hold_req = hold_req - 1;
    end else begin
      out_chan.ready = calm ? 1'b1 : ($urandom_range(99) >= 30);
    end
  end

  // offer one direction beat, idling first at random; hold until accepted
  task automatic send_dir(logic signed [15:0] d);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 30) begin
      in_chan.valid = 1'b0;
      repeat ($urandom_range(4)) @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.direction = d;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // drop valid and wait until every density has come back
  task automatic drain();
    @(negedge clk);
    in_chan.valid = 1'b0;
    wait (pending == 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_regs(logic [15:0] s, logic [23:0] cs, logic signed [15:0] m);
    write_reg(CFG_SPREAD, 24'(s));
    write_reg(CFG_NORM, cs);
    write_reg(CFG_MEAN, {8'h00, m});
    mean_now = m;
  endtask

  // directions near the mean, where the density is not zero, near the opposite direction, or anywhere
  function automatic logic signed [15:0] pick_dir();
    case ($urandom_range(3))
      0:       return 16'($urandom);
      1:       return mean_now + 16'(signed'($urandom_range(8000)) - 4000);
      2:       return mean_now + 16'(signed'($urandom_range(600)) - 300);
      default: return mean_now + 16'h8000 + 16'(signed'($urandom_range(40)) - 20);
    endcase
  endfunction

  initial begin
    logic [15:0] s;
    logic [23:0] cs;
    logic signed [15:0] m;
    mean_now = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset registers, field extremes, opposite direction
    send_dir(16'sh0000);
    send_dir(16'sh7FFF);
    send_dir(-16'sh8000);
    send_dir(16'sh0001);
    send_dir(-16'sh0001);
    drain();
    // zero spread: density equals C_s, also at the opposite direction
    set_regs(16'd0, 24'hFFFFFF, 16'sh1234);
    send_dir(16'sh1234);
    send_dir(16'sh1234 + 16'sh8000);
    send_dir(16'sh0000);
    drain();
    // ignored write to an index past the list must leave s alone
    write_reg(CFG_NONE, 24'hFFFFFF);
    send_dir(16'sh7000);
    drain();
    // huge spread: deep underflow away from the mean
    set_regs(16'hFFFF, 24'hFFFFFF, -16'sh8000);
    send_dir(-16'sh8000);
    send_dir(-16'sh7F00);
    send_dir(16'sh0000);
    send_dir(16'sh7FFF);
    drain();
    set_regs(16'd1, 24'd0, 16'sh7FFF);
    send_dir(16'sh7FFF);
    send_dir(16'sh0000);
    send_dir(-16'sh8000);
    drain();

    // random phases through several register settings
    for (int p = 0; p < 10; p++) begin
      case (p % 5)
        0: s = 16'($urandom_range(4096));
        1: s = 16'hFFFF;
        2: s = 16'd0;
        3: s = 16'($urandom);
        default: s = 16'($urandom_range(768, 64));
      endcase
      cs = (p == 3) ? 24'hFFFFFF : (p == 7) ? 24'd0 : 24'($urandom);
      m  = (p == 1) ? 16'sh7FFF : (p == 6) ? -16'sh8000 : 16'($urandom);
      set_regs(s, cs, m);
      calm = (p == 4);
      for (int i = 0; i < 125; i++) begin
        // hold off the receiver long enough to fill every cell
        if (p == 2 && i == 10) hold_req = 300;
        // pause the sender until all densities are back
        if (p == 5 && i == 60) drain();
        send_dir(pick_dir());
      end
      calm = 1'b0;
      drain();
    end

    repeat (LATENCY) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/cs2s_pkg.sv
rtl/core/cs2s_dir_if.sv
rtl/core/cs2s_dens_if.sv
rtl/core/cs2s_horner_cell.sv
rtl/core/cs2s_norm_cell.sv
rtl/core/cs2s_sq_cell.sv
rtl/core/cs2s_exp_cell.sv
rtl/core/cos_2s_directional_spreading.sv
bench/cs2s_checker.sv
bench/cos_2s_directional_spreading_tb.sv
